>>> rtl/pts_pkg.sv
package pts_pkg;

    localparam int MAX_THREADS   = 8;
    localparam int PRIORITY_BITS = 8;
    localparam int DELAY_BITS    = 32;

    localparam int IDX_W      = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CNT_W      = $clog2(MAX_THREADS + 1);
    localparam int MODE_W     = 2;
    localparam int PRIO_IN_W  = 8;
    localparam int DELAY_IN_W = 32;
    localparam int OUT_IDX_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_DELAY  = 2'd2,
        MODE_SCHED  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      addr;
        logic [DELAY_BITS-1:0] data;
    } t_dly_wr;

    typedef struct packed {
        logic             clr;
        logic             vld;
        logic             tick;
        logic [IDX_W-1:0] idx;
    } t_pick_ctl;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_pick_res;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] chosen_index;
        logic                 chosen_idle;
        logic                 switch_request;
        logic [OUT_IDX_W-1:0] created_index;
        logic                 table_full;
    } t_out_item;

    function automatic logic [PRIORITY_BITS-1:0] to_prio(input logic [PRIO_IN_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[PRIORITY_BITS-1:0];
    endfunction

    function automatic logic [DELAY_BITS-1:0] to_delay(input logic [DELAY_IN_W-1:0] v);
        return v[DELAY_BITS-1:0];
    endfunction

    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_IDX_W-1:0];
    endfunction

endpackage

>>> rtl/pts_if.sv
interface pts_in_if import pts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [PRIO_IN_W-1:0]  priority_req;
    logic [DELAY_IN_W-1:0] delay_ticks;

    modport source (output valid, output mode, output priority_req, output delay_ticks,
                    input ready);
    modport sink   (input valid, input mode, input priority_req, input delay_ticks,
                    output ready);
endinterface

interface pts_out_if import pts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] chosen_index;
    logic                 chosen_idle;
    logic                 switch_request;
    logic [OUT_IDX_W-1:0] created_index;
    logic                 table_full;

    modport source (output valid, output chosen_index, output chosen_idle,
                    output switch_request, output created_index, output table_full,
                    input ready);
    modport sink   (input valid, input chosen_index, input chosen_idle,
                    input switch_request, input created_index, input table_full,
                    output ready);
endinterface

>>> rtl/pts_table.sv
module pts_table import pts_pkg::*; (
    input  logic                     i_clk,
    input  logic [IDX_W-1:0]         i_rd_addr,
    output logic [PRIORITY_BITS-1:0] o_rd_prio,
    output logic [DELAY_BITS-1:0]    o_rd_delay,
    input  logic                     i_prio_wr_en,
    input  logic [IDX_W-1:0]         i_prio_wr_addr,
    input  logic [PRIORITY_BITS-1:0] i_prio_wr_data,
    input  t_dly_wr                  i_dly_wr
);

    logic [PRIORITY_BITS-1:0] r_prio_mem [MAX_THREADS];
    logic [DELAY_BITS-1:0]    r_dly_mem  [MAX_THREADS];
    logic [PRIORITY_BITS-1:0] r_rd_prio;
    logic [DELAY_BITS-1:0]    r_rd_delay;

    always_ff @(posedge i_clk) begin
        if (i_prio_wr_en) begin
            r_prio_mem[i_prio_wr_addr] <= i_prio_wr_data;
        end
        r_rd_prio <= r_prio_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_dly_wr.en) begin
            r_dly_mem[i_dly_wr.addr] <= i_dly_wr.data;
        end
        r_rd_delay <= r_dly_mem[i_rd_addr];
    end

    assign o_rd_prio  = r_rd_prio;
    assign o_rd_delay = r_rd_delay;

endmodule

>>> rtl/pts_pick.sv
module pts_pick import pts_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pick_ctl                i_ctl,
    input  logic [PRIORITY_BITS-1:0] i_rd_prio,
    input  logic [DELAY_BITS-1:0]    i_rd_delay,
    output t_dly_wr                  o_wb,
    output t_pick_res                o_res
);

    logic                     r_found;
    logic [IDX_W-1:0]         r_best_idx;
    logic [PRIORITY_BITS-1:0] r_best_prio;

    logic dly_nz;
    logic ready_now;
    logic better;
    logic take;

    always_comb begin
        dly_nz    = |i_rd_delay;
        // tick: a counter of one reaches zero in this pass
        ready_now = i_ctl.tick ? (i_rd_delay[DELAY_BITS-1:1] == '0) : !dly_nz;
        better    = !r_found || (i_rd_prio > r_best_prio);
        take      = i_ctl.vld && ready_now && better;
        o_wb.en   = i_ctl.vld && i_ctl.tick && dly_nz;
        o_wb.addr = i_ctl.idx;
        o_wb.data = i_rd_delay - DELAY_BITS'(1);
        o_res.found = r_found;
        o_res.idx   = r_best_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx  <= i_ctl.idx;
            r_best_prio <= i_rd_prio;
        end
    end

endmodule

>>> rtl/priority_thread_scheduler_unit.sv
// Channel  Dir  Role    Payload
// i_cmd    in   sink    mode, priority_req, delay_ticks
// o_res    out  source  chosen_index, chosen_idle, switch_request, created_index, table_full
//
// Create: the result is captured at input transfer and copied into the output register from the done state.
// Tick, delay, schedule: the pass walks the thread
// table one entry per cycle through its single registered read port.
// Reset clears the thread count and marks no thread running; table entries are not cleared.
// A result waits in the output register; a finished item holds until that register frees,
// and i_cmd.ready stays low from transfer until the result is loaded.
module priority_thread_scheduler_unit import pts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pts_in_if.sink   i_cmd,
    pts_out_if.source o_res
);

    t_state                  r_state, n_state;
    t_mode                   r_mode;
    logic [CNT_W-1:0]        r_total;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_ev_vld;
    logic [IDX_W-1:0]        r_ev_idx;
    logic                    r_run_none;
    logic                    r_run_idle;
    logic [IDX_W-1:0]        r_run_idx;
    t_out_item               r_res;
    t_out_item               r_out;
    logic                    r_out_vld;

    logic                     acc;
    t_mode                    in_mode;
    logic                     full;
    logic                     do_create;
    logic                     rd_en;
    logic                     scan_end;
    logic                     out_free;
    logic                     out_load;
    logic                     switch_req;
    logic                     prio_wr_en;
    t_dly_wr                  dly_wr;
    t_dly_wr                  pick_wb;
    t_pick_ctl                pick_ctl;
    t_pick_res                pick_res;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [DELAY_BITS-1:0]    rd_delay;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign acc         = i_cmd.valid && i_cmd.ready;
    assign in_mode     = t_mode'(i_cmd.mode);
    assign full        = (r_total >= CNT_W'(MAX_THREADS));
    assign do_create   = acc && (in_mode == MODE_CREATE) && !full;
    assign rd_en       = (r_state == ST_SCAN) && (r_idx < r_total);
    assign scan_end    = (r_state == ST_SCAN) && !rd_en && !r_ev_vld;
    assign out_free    = !r_out_vld || o_res.ready;
    assign out_load    = (r_state == ST_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_state = (in_mode == MODE_CREATE) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        pick_ctl.clr  = acc;
        pick_ctl.vld  = r_ev_vld;
        pick_ctl.tick = (r_mode == MODE_TICK);
        pick_ctl.idx  = r_ev_idx;
        prio_wr_en    = do_create;
        if (do_create) begin
            dly_wr.en   = 1'b1;
            dly_wr.addr = r_total[IDX_W-1:0];
            dly_wr.data = '0;
        end else if (acc && (in_mode == MODE_DELAY) && !r_run_none && !r_run_idle) begin
            dly_wr.en   = 1'b1;
            dly_wr.addr = r_run_idx;
            dly_wr.data = to_delay(i_cmd.delay_ticks);
        end else begin
            dly_wr = pick_wb;
        end
        if (r_run_none) begin
            switch_req = 1'b1;
        end else if (pick_res.found) begin
            switch_req = r_run_idle || (r_run_idx != pick_res.idx);
        end else begin
            switch_req = !r_run_idle;
        end
    end

    pts_table u_table (
        .i_clk          (i_clk),
        .i_rd_addr      (r_idx[IDX_W-1:0]),
        .o_rd_prio      (rd_prio),
        .o_rd_delay     (rd_delay),
        .i_prio_wr_en   (prio_wr_en),
        .i_prio_wr_addr (r_total[IDX_W-1:0]),
        .i_prio_wr_data (to_prio(i_cmd.priority_req)),
        .i_dly_wr       (dly_wr)
    );

    pts_pick u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (pick_ctl),
        .i_rd_prio  (rd_prio),
        .i_rd_delay (rd_delay),
        .o_wb       (pick_wb),
        .o_res      (pick_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_total    <= '0;
            r_idx      <= '0;
            r_ev_vld   <= 1'b0;
            r_run_none <= 1'b1;
            r_run_idle <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= rd_en;
            if (do_create) begin
                r_total <= r_total + CNT_W'(1);
            end
            if (acc) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (scan_end) begin
                r_run_none <= 1'b0;
                r_run_idle <= !pick_res.found;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx <= r_idx[IDX_W-1:0];
        if (acc) begin
            r_mode <= in_mode;
            r_res  <= '{chosen_index:   '0,
                        chosen_idle:    1'b0,
                        switch_request: 1'b0,
                        created_index:  ((in_mode == MODE_CREATE) && !full)
                                        ? to_out_idx(r_total[IDX_W-1:0]) : '0,
                        table_full:     (in_mode == MODE_CREATE) && full};
        end
        if (scan_end) begin
            r_run_idx                <= pick_res.idx;
            r_res.chosen_index       <= pick_res.found ? to_out_idx(pick_res.idx) : '0;
            r_res.chosen_idle        <= !pick_res.found;
            r_res.switch_request     <= switch_req;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.chosen_index   = r_out.chosen_index;
    assign o_res.chosen_idle    = r_out.chosen_idle;
    assign o_res.switch_request = r_out.switch_request;
    assign o_res.created_index  = r_out.created_index;
    assign o_res.table_full     = r_out.table_full;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_THREADS))
        else $error("thread count above table size");

    a_create_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_create |=> (r_total == $past(r_total) + CNT_W'(1)))
        else $error("create did not add a thread");

    a_run_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_end |=> (!r_run_none && (r_run_idle == !$past(pick_res.found))))
        else $error("running thread not updated after pass");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.chosen_idle) |-> (r_out.chosen_index == '0))
        else $error("idle pick with nonzero index");

    a_wb_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pick_wb.en |-> (CNT_W'(pick_wb.addr) < r_total))
        else $error("delay write-back outside created threads");

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam logic [3:0] RUN_IDLE = 4'd14;
    localparam logic [3:0] RUN_NONE = 4'd15;
    localparam int RANDOM_CMDS = 1600;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_START = 3000;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        t_mode                 mode;
        logic [PRIO_IN_W-1:0]  prio;
        logic [DELAY_IN_W-1:0] ticks;
        bit                    drain;
    } t_sched_cmd;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pts_in_if  cmd_if ();
    pts_out_if res_if ();

    priority_thread_scheduler_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // scheduler mirror
    logic [PRIORITY_BITS-1:0] tbl_prio  [MAX_THREADS];
    logic [DELAY_BITS-1:0]    tbl_delay [MAX_THREADS];
    int unsigned              tbl_count;
    logic [3:0]               cur_thread;

    t_sched_cmd pending_cmds [$];
    t_out_item  sched_results_due [$];

    int  fail_count = 0;
    int  cmds_sent = 0;
    int  results_seen = 0;
    bit  no_gaps = 1'b0;
    bit  rx_hold = 1'b0;

    function automatic t_out_item schedule_step(t_sched_cmd c);
        t_out_item r;
        bit        found;
        int        pick;
        logic [3:0] nxt;
        r = '0;
        found = 1'b0;
        pick = 0;
        case (c.mode)
            MODE_CREATE: begin
                if (tbl_count >= MAX_THREADS) begin
                    r.table_full = 1'b1;
                end else begin
                    tbl_prio[tbl_count]  = c.prio[PRIORITY_BITS-1:0];
                    tbl_delay[tbl_count] = '0;
                    r.created_index = OUT_IDX_W'(tbl_count);
                    tbl_count++;
                end
                return r;
            end
            MODE_TICK: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_delay[i] != 0) tbl_delay[i] = tbl_delay[i] - DELAY_BITS'(1);
                end
            end
            MODE_DELAY: begin
                if (cur_thread != RUN_IDLE && cur_thread != RUN_NONE && cur_thread < tbl_count)
                    tbl_delay[cur_thread] = c.ticks[DELAY_BITS-1:0];
            end
            default: ;
        endcase
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_delay[i] == 0 && (!found || tbl_prio[i] > tbl_prio[pick])) begin
                pick = i;
                found = 1'b1;
            end
        end
        nxt = found ? 4'(pick) : RUN_IDLE;
        r.chosen_index   = found ? OUT_IDX_W'(pick) : '0;
        r.chosen_idle    = !found;
        r.switch_request = (nxt != cur_thread);
        cur_thread = nxt;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_cmd(t_mode m, logic [PRIO_IN_W-1:0] p, logic [DELAY_IN_W-1:0] d,
                           bit drain);
        t_sched_cmd c;
        c.mode = m;
        c.prio = p;
        c.ticks = d;
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    task automatic check_field(string fname, int unsigned e, int unsigned a);
        if (e != a) begin
            $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
                     $time, results_seen, fname, e, a);
            fail_count++;
        end
    endtask

    // driver
    t_sched_cmd cur_cmd;
    bit         offering;
    int         tx_gap;

    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
            offering = 1'b0;
            tx_gap = 0;
            tbl_count = 0;
            cur_thread = RUN_NONE;
            for (int i = 0; i < MAX_THREADS; i++) begin
                tbl_prio[i] = '0;
                tbl_delay[i] = '0;
            end
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                sched_results_due.push_back(schedule_step(cur_cmd));
                cmds_sent++;
                no_gaps <= ((cmds_sent / 150) % 4) == 3;
                tx_gap = pick_gap();
                offering = 1'b0;
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_cmds.size() > 0 &&
                             !(pending_cmds[0].drain && results_seen != cmds_sent)) begin
                    cur_cmd = pending_cmds.pop_front();
                    offering = 1'b1;
                end
            end
            cmd_if.valid        <= offering;
            cmd_if.mode         <= cur_cmd.mode;
            cmd_if.priority_req <= cur_cmd.prio;
            cmd_if.delay_ticks  <= cur_cmd.ticks;
        end
    end

    // long receiver hold-off so the input side backs up
    int hold_clk = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            hold_clk <= hold_clk + 1;
            rx_hold <= (hold_clk >= HOLD_START) && (hold_clk < HOLD_START + HOLD_CYCLES);
        end
    end

    // monitor
    int rx_stall;

    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (sched_results_due.size() == 0) begin
                    $display({"%0t: unexpected result: expected none, actual idx=%0d",
                              " idle=%0d sw=%0d created=%0d full=%0d"},
                             $time, res_if.chosen_index, res_if.chosen_idle,
                             res_if.switch_request, res_if.created_index, res_if.table_full);
                    fail_count++;
                end else begin
                    t_out_item e;
                    e = sched_results_due.pop_front();
                    check_field("chosen_index", 32'(e.chosen_index),
                                32'(res_if.chosen_index));
                    check_field("chosen_idle", 32'(e.chosen_idle),
                                32'(res_if.chosen_idle));
                    check_field("switch_request", 32'(e.switch_request),
                                32'(res_if.switch_request));
                    check_field("created_index", 32'(e.created_index),
                                32'(res_if.created_index));
                    check_field("table_full", 32'(e.table_full),
                                32'(res_if.table_full));
                end
                results_seen <= results_seen + 1;
                rx_stall = pick_gap();
            end
            if (rx_hold) begin
                res_if.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int r;
        int phase;
        t_mode m;
        logic [DELAY_IN_W-1:0] d;

        cmd_if.valid = 1'b0;
        cmd_if.mode = MODE_CREATE;
        cmd_if.priority_req = '0;
        cmd_if.delay_ticks = '0;
        res_if.ready = 1'b0;
        cur_cmd = '{MODE_CREATE, '0, '0, 1'b0};

        // empty table: first pass switches to idle, delay with nothing running is dropped
        add_cmd(MODE_SCHED,  8'd0,   32'd0,        1'b0);
        add_cmd(MODE_DELAY,  8'd255, 32'hFFFFFFFF, 1'b0);
        add_cmd(MODE_TICK,   8'd0,   32'd0,        1'b0);
        add_cmd(MODE_CREATE, 8'd0,   32'hFFFFFFFF, 1'b0);
        add_cmd(MODE_SCHED,  8'd0,   32'd0,        1'b0);
        // equal priorities: lowest index wins
        add_cmd(MODE_CREATE, 8'd255, 32'd0,        1'b0);
        add_cmd(MODE_CREATE, 8'd255, 32'd0,        1'b0);
        add_cmd(MODE_SCHED,  8'd0,   32'd0,        1'b0);
        add_cmd(MODE_DELAY,  8'd0,   32'd2,        1'b0);
        add_cmd(MODE_DELAY,  8'd0,   32'd1,        1'b0);
        add_cmd(MODE_TICK,   8'd0,   32'd0,        1'b0);
        add_cmd(MODE_TICK,   8'd0,   32'd0,        1'b0);
        add_cmd(MODE_DELAY,  8'd0,   32'd0,        1'b0);
        add_cmd(MODE_CREATE, 8'd128, 32'd0,        1'b0);
        add_cmd(MODE_CREATE, 8'd1,   32'd0,        1'b0);
        add_cmd(MODE_CREATE, 8'd254, 32'd0,        1'b0);
        add_cmd(MODE_CREATE, 8'd77,  32'd0,        1'b0);
        add_cmd(MODE_CREATE, 8'd200, 32'd0,        1'b0);
        // full table
        add_cmd(MODE_CREATE, 8'd255, 32'd0,        1'b0);
        add_cmd(MODE_CREATE, 8'd0,   32'd0,        1'b0);
        add_cmd(MODE_SCHED,  8'd0,   32'd0,        1'b0);
        add_cmd(MODE_DELAY,  8'd0,   32'hFFFFFFFF, 1'b0);
        add_cmd(MODE_DELAY,  8'd0,   32'd3,        1'b0);
        add_cmd(MODE_TICK,   8'd0,   32'd0,        1'b1);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            phase = (n / 200) % 3;
            r = $urandom_range(0, 99);
            if (r < 8)
                m = MODE_CREATE;
            else if (r < ((phase == 1) ? 28 : (phase == 2) ? 65 : 45))
                m = MODE_TICK;
            else if (r < ((phase == 1) ? 88 : (phase == 2) ? 82 : 78))
                m = MODE_DELAY;
            else
                m = MODE_SCHED;
            d = $urandom();
            if (m == MODE_DELAY) begin
                r = $urandom_range(0, 99);
                if (r < 10)      d = '0;
                else if (r < 80) d = $urandom_range(1, 6);
                else             d = $urandom_range(7, 30);
            end
            add_cmd(m, PRIO_IN_W'($urandom_range(0, 255)), d, (n % 200) == 199);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk);
        while (pending_cmds.size() > 0 || cmd_if.valid || sched_results_due.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && sched_results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #12ms;
        $display("%0t: timeout with %0d results outstanding", $time, sched_results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
